// ===== src/q41_pkg.sv =====
`timescale 1ns / 1ps
package q41_pkg;

    localparam int BLOCK_SIZE = 32;
    localparam int HALF_BLOCK = BLOCK_SIZE / 2;
    localparam logic [31:0] NAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;

    // Every finite value is a multiple of 2^-24 below 2^21, so it fits a
    // 46-bit magnitude in units of 2^-24.
    localparam int FIX_W = 46;

    typedef struct packed {
        logic       sign;
        logic       is_inf;
        logic       is_nan;
        logic [FIX_W-1:0] mag;
    } fix_t;

    typedef struct packed {
        logic [31:0] low_value;
        logic [31:0] high_value;
        logic [3:0]  low_position;
        logic [4:0]  high_position;
        logic        row_done;
    } result_t;

endpackage

// ===== src/q4_1_block_dequantizer_unit.sv =====
`timescale 1ns / 1ps
// An accepted input transaction passes through the registered stages below, in order, to its result.
// Throughput: one transaction per cycle; a stall holds every stage in place.
// Stages: half decode, nibble product, signed add, normalise and round.
// Reset clears the stage valid bits only; the data path needs no reset.
module q4_1_block_dequantizer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] scale_half,
    input  logic [15:0] min_half,
    input  logic [7:0]  quant_byte,
    input  logic [3:0]  byte_index,
    input  logic        end_of_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] low_value,
    output logic [31:0] high_value,
    output logic [3:0]  low_position,
    output logic [4:0]  high_position,
    output logic        row_done
);

    localparam int FW = q41_pkg::FIX_W;

    logic [3:0] vld_reg;
    logic       adv;
    assign adv      = !out_stall || !vld_reg[3];
    assign in_stall = !adv;

    function automatic q41_pkg::fix_t half_to_fix(input logic [15:0] h);
        q41_pkg::fix_t f;
        logic [10:0] sig;
        f.sign   = h[15];
        f.is_inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        f.is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        sig      = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
        if (h[14:10] == 5'd0)
        begin
            f.mag = FW'(sig);
        end
        else
        begin
            f.mag = FW'(sig) << (h[14:10] - 5'd1);
        end
        return f;
    endfunction

    // Stage 1: decode.
    q41_pkg::fix_t s1_s_reg, s1_m_reg;
    logic [7:0] s1_q_reg;
    logic [3:0] s1_i_reg;
    logic       s1_e_reg;
    // Stage 2: products.
    q41_pkg::fix_t s2_m_reg;
    logic [FW-1:0] s2_pl_reg, s2_ph_reg;
    logic s2_ps_reg, s2_zl_reg, s2_zh_reg, s2_si_reg, s2_sn_reg;
    logic [3:0] s2_i_reg;
    logic       s2_e_reg;
    // Stage 3: sums.
    q41_pkg::fix_t s3_l_reg, s3_h_reg;
    logic [3:0] s3_i_reg;
    logic       s3_e_reg;
    q41_pkg::result_t s4_reg;

    function automatic q41_pkg::fix_t add_fix(input logic ps, input logic [FW-1:0] p,
        input logic zq, input logic si, input logic sn, input q41_pkg::fix_t m);
        q41_pkg::fix_t r;
        logic pinf;
        pinf     = si && !zq;
        r.is_nan = sn || m.is_nan || (si && zq) || (pinf && m.is_inf && (ps != m.sign));
        r.is_inf = pinf || m.is_inf;
        r.sign   = pinf ? ps : (m.is_inf ? m.sign : 1'b0);
        r.mag    = '0;
        if (!r.is_inf)
        begin
            if (ps == m.sign)
            begin
                r.mag  = p + m.mag;
                r.sign = ps;
            end
            else if (p >= m.mag)
            begin
                r.mag  = p - m.mag;
                r.sign = (p == m.mag) ? 1'b0 : ps;
            end
            else
            begin
                r.mag  = m.mag - p;
                r.sign = m.sign;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] fix_to_float(input q41_pkg::fix_t f);
        logic [5:0]  lz;
        logic [FW-1:0] n;
        logic [23:0] mant;
        logic        g, st;
        logic [24:0] rnd;
        logic [7:0]  ex;
        logic        found;
        lz    = 6'd0;
        found = 1'b0;
        for (int k = FW - 1; k >= 0; k--)
        begin
            if (!found && f.mag[k])
            begin
                lz    = 6'(FW - 1 - k);
                found = 1'b1;
            end
        end
        n    = f.mag << lz;
        mant = n[FW-1 -: 24];
        g    = n[FW-25];
        st   = |n[FW-26:0];
        rnd  = {1'b0, mant} + 25'(g && (st || mant[0]));
        // Leading bit at 2^(FW-1-lz-24); biased exponent adds 127.
        ex   = 8'(127 + FW - 1 - 24) - 8'(lz) + 8'(rnd[24]);
        if (f.is_nan)
            return q41_pkg::NAN_BITS;
        else if (f.is_inf)
            return {f.sign, q41_pkg::INF_BITS[30:0]};
        else if (!found)
            return {f.sign, 31'd0};
        else
            return {f.sign, ex, rnd[24] ? rnd[23:1] : rnd[22:0]};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_s_reg <= half_to_fix(scale_half);
            s1_m_reg <= half_to_fix(min_half);
            s1_q_reg <= quant_byte;
            s1_i_reg <= byte_index;
            s1_e_reg <= end_of_row;

            s2_m_reg  <= s1_m_reg;
            s2_pl_reg <= s1_s_reg.mag * FW'(s1_q_reg[3:0]);
            s2_ph_reg <= s1_s_reg.mag * FW'(s1_q_reg[7:4]);
            s2_ps_reg <= s1_s_reg.sign;
            s2_zl_reg <= (s1_q_reg[3:0] == 4'd0);
            s2_zh_reg <= (s1_q_reg[7:4] == 4'd0);
            s2_si_reg <= s1_s_reg.is_inf;
            s2_sn_reg <= s1_s_reg.is_nan;
            s2_i_reg  <= s1_i_reg;
            s2_e_reg  <= s1_e_reg;

            s3_l_reg <= add_fix(s2_ps_reg, s2_pl_reg, s2_zl_reg, s2_si_reg, s2_sn_reg, s2_m_reg);
            s3_h_reg <= add_fix(s2_ps_reg, s2_ph_reg, s2_zh_reg, s2_si_reg, s2_sn_reg, s2_m_reg);
            s3_i_reg <= s2_i_reg;
            s3_e_reg <= s2_e_reg;

            s4_reg.low_value     <= fix_to_float(s3_l_reg);
            s4_reg.high_value    <= fix_to_float(s3_h_reg);
            s4_reg.low_position  <= s3_i_reg;
            s4_reg.high_position <= {1'b0, s3_i_reg} + 5'(q41_pkg::HALF_BLOCK);
            s4_reg.row_done      <= s3_e_reg;
        end
    end

    // Signed zero: an exact cancellation gives +0, but two zeros of the same
    // sign keep it, which the add above handles through the equal-sign branch.
    assign out_valid     = vld_reg[3];
    assign low_value     = s4_reg.low_value;
    assign high_value    = s4_reg.high_value;
    assign low_position  = s4_reg.low_position;
    assign high_position = s4_reg.high_position;
    assign row_done      = s4_reg.row_done;

endmodule

// ===== src/q4_1_block_dequantizer_checker.sv =====
`timescale 1ns / 1ps
module q4_1_block_dequantizer_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] low_value,
    input logic [31:0] high_value,
    input logic [3:0]  low_position,
    input logic [4:0]  high_position
);

    // A waiting result holds its low value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(low_value))
        else $error("result changed while stalled");

    // The input is stalled only when the output is.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && out_valid)
        else $error("input stalled without output back-pressure");

    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> high_position == {1'b0, low_position} + 5'd16)
        else $error("positions inconsistent");

    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && high_value[30:23] == 8'hFF && high_value[22:0] != 23'd0
        |-> high_value == 32'h7FC0_0000)
        else $error("non-canonical NaN");

endmodule

bind q4_1_block_dequantizer_unit q4_1_block_dequantizer_checker u_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .low_value(low_value),
    .high_value(high_value), .low_position(low_position), .high_position(high_position)
);

// ===== tb/sv/tb_q4_1_block_dequantizer_unit.sv =====
`timescale 1ns / 1ps
module tb_q4_1_block_dequantizer_unit;

    localparam int ITEM_COUNT = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [15:0] scale;
        logic [15:0] minimum;
        logic [7:0]  qbyte;
        logic [3:0]  index;
        logic        eor;
        logic        known;
        logic [31:0] low_known;
        logic [31:0] high_known;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] scale_half;
    logic [15:0] min_half;
    logic [7:0]  quant_byte;
    logic [3:0]  byte_index;
    logic        end_of_row;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] low_value;
    logic [31:0] high_value;
    logic [3:0]  low_position;
    logic [4:0]  high_position;
    logic        row_done;

    q41_pkg::result_t pending_results[$];
    int          error_count;
    int          cycle_count;

    q4_1_block_dequantizer_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .scale_half(scale_half),
        .min_half(min_half),
        .quant_byte(quant_byte),
        .byte_index(byte_index),
        .end_of_row(end_of_row),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .low_value(low_value),
        .high_value(high_value),
        .low_position(low_position),
        .high_position(high_position),
        .row_done(row_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    // Binary16 to an exact fixed-point magnitude in units of 2^-24.
    function automatic q41_pkg::fix_t half_decode(input logic [15:0] h);
        q41_pkg::fix_t f;
        logic [4:0] e;
        begin
            f = '0;
            e = h[14:10];
            f.sign = h[15];
            if (e == 5'h1f)
            begin
                if (h[9:0] != 0)
                    f.is_nan = 1'b1;
                else
                    f.is_inf = 1'b1;
            end
            else if (e == 0)
                f.mag = q41_pkg::FIX_W'(h[9:0]);
            else
                f.mag = q41_pkg::FIX_W'({1'b1, h[9:0]}) << (e - 1);
            return f;
        end
    endfunction

    // Exact nibble product and sum, one round-to-nearest-even into binary32.
    function automatic logic [31:0] dequant_value(input logic [3:0] q,
                                                  input q41_pkg::fix_t s,
                                                  input q41_pkg::fix_t m);
        q41_pkg::fix_t p;
        logic [63:0] total;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] halfway;
        logic sgn;
        int msb;
        int sh;
        logic [7:0] ex;
        begin
            p = s;
            if (s.is_inf && q == 0)
                return q41_pkg::NAN_BITS;
            p.mag = q41_pkg::FIX_W'(s.mag * q);
            if (p.is_nan || m.is_nan)
                return q41_pkg::NAN_BITS;
            if (p.is_inf && m.is_inf)
                return (p.sign == m.sign) ? {p.sign, q41_pkg::INF_BITS[30:0]}
                                          : q41_pkg::NAN_BITS;
            if (p.is_inf)
                return {p.sign, q41_pkg::INF_BITS[30:0]};
            if (m.is_inf)
                return {m.sign, q41_pkg::INF_BITS[30:0]};
            if (p.sign == m.sign)
            begin
                total = 64'(p.mag) + 64'(m.mag);
                sgn = p.sign;
            end
            else if (p.mag >= m.mag)
            begin
                total = 64'(p.mag) - 64'(m.mag);
                sgn = p.sign;
            end
            else
            begin
                total = 64'(m.mag) - 64'(p.mag);
                sgn = m.sign;
            end
            // An exact zero is negative only when both addends are.
            if (total == 0)
                return {p.sign & m.sign, 31'b0};
            msb = 0;
            for (int i = 0; i < 64; i++)
                if (total[i])
                    msb = i;
            if (msb <= 23)
                keep = total << (23 - msb);
            else
            begin
                sh = msb - 23;
                keep = total >> sh;
                rem = total & ((64'd1 << sh) - 1);
                halfway = 64'd1 << (sh - 1);
                if (rem > halfway || (rem == halfway && keep[0]))
                    keep++;
                if (keep[24])
                begin
                    keep = keep >> 1;
                    msb++;
                end
            end
            ex = 8'(msb + 103);
            return {sgn, ex, keep[22:0]};
        end
    endfunction

    function automatic q41_pkg::result_t dequant_byte(input logic [15:0] sh,
                                                      input logic [15:0] mh,
                                                      input logic [7:0] qb,
                                                      input logic [3:0] idx,
                                                      input logic eor);
        q41_pkg::result_t r;
        q41_pkg::fix_t s;
        q41_pkg::fix_t m;
        begin
            s = half_decode(sh);
            m = half_decode(mh);
            r.low_value = dequant_value(qb[3:0], s, m);
            r.high_value = dequant_value(qb[7:4], s, m);
            r.low_position = idx;
            r.high_position = 5'(idx + q41_pkg::HALF_BLOCK);
            r.row_done = eor;
            return r;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_results.push_back(dequant_byte(scale_half, min_half, quant_byte,
                                                   byte_index, end_of_row));
    end

    always @(posedge clk)
    begin
        q41_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result transaction at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (low_value !== want.low_value)
                    report("low_value", low_value, want.low_value);
                if (high_value !== want.high_value)
                    report("high_value", high_value, want.high_value);
                if (low_position !== want.low_position)
                    report("low_position", 32'(low_position), 32'(want.low_position));
                if (high_position !== want.high_position)
                    report("high_position", 32'(high_position), 32'(want.high_position));
                if (row_done !== want.row_done)
                    report("row_done", 32'(row_done), 32'(want.row_done));
            end
        end
    end

    // Receiver: quiet stretches, light random stalls and long stall runs, chosen at random.
    int stall_mode;
    int stall_run;
    always @(posedge clk)
    begin
        if (cycle_count % 300 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 99) < 30);
        else if (stall_mode == 2 && $urandom_range(0, 99) < 10)
        begin
            stall_run <= $urandom_range(1, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL q4_1_block_dequantizer_unit");
            $finish;
        end
    end

    int burst_left;

    // Drives one transaction and holds it until it is accepted.
    task automatic send_byte(input logic [15:0] sh, input logic [15:0] mh, input logic [7:0] qb,
                             input logic [3:0] idx, input logic eor);
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            in_valid <= 1'b1;
            scale_half <= sh;
            min_half <= mh;
            quant_byte <= qb;
            byte_index <= idx;
            end_of_row <= eor;
            do
                @(posedge clk);
            while (in_stall);
        end
    endtask

    function automatic logic [15:0] pick_half();
        begin
            case ($urandom_range(0, 9))
                0: return 16'($urandom);
                1: return {$urandom_range(0, 1) == 1, 5'h1f, 10'($urandom_range(0, 3))};
                2: return {$urandom_range(0, 1) == 1, 5'h00, 10'($urandom)};
                3: return {$urandom_range(0, 1) == 1, 15'h0};
                default: return {$urandom_range(0, 1) == 1, 5'($urandom_range(1, 30)),
                                 10'($urandom)};
            endcase
        end
    endfunction

    stim_row_t directed_rows[] = '{
        '{16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{16'h3C00, 16'h0000, 8'hF1, 4'd15, 1'b1, 1'b1, 32'h3F80_0000, 32'h4170_0000},
        '{16'h3C00, 16'h3C00, 8'h0F, 4'd7,  1'b0, 1'b1, 32'h4180_0000, 32'h3F80_0000},
        '{16'h8000, 16'h8000, 8'h00, 4'd1,  1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000},
        '{16'h7E00, 16'h3C00, 8'h5A, 4'd2,  1'b0, 1'b1, q41_pkg::NAN_BITS, q41_pkg::NAN_BITS},
        '{16'h3C00, 16'hFFFF, 8'hFF, 4'd3,  1'b1, 1'b1, q41_pkg::NAN_BITS, q41_pkg::NAN_BITS},
        '{16'h7C00, 16'h0000, 8'h10, 4'd4,  1'b0, 1'b1, q41_pkg::NAN_BITS, q41_pkg::INF_BITS},
        '{16'h7C00, 16'hFC00, 8'h20, 4'd5,  1'b0, 1'b1, q41_pkg::NAN_BITS, q41_pkg::NAN_BITS},
        '{16'h3C00, 16'hFC00, 8'h31, 4'd6,  1'b0, 1'b1, 32'hFF80_0000, 32'hFF80_0000},
        '{16'h0001, 16'h0000, 8'hF1, 4'd8,  1'b0, 1'b0, 32'h0, 32'h0},
        '{16'h83FF, 16'h0001, 8'hF7, 4'd9,  1'b0, 1'b0, 32'h0, 32'h0},
        '{16'h7BFF, 16'h7BFF, 8'hFF, 4'd10, 1'b0, 1'b0, 32'h0, 32'h0},
        '{16'hFBFF, 16'h7BFF, 8'hF0, 4'd11, 1'b1, 1'b0, 32'h0, 32'h0},
        '{16'hBC00, 16'h3C00, 8'h10, 4'd12, 1'b0, 1'b0, 32'h0, 32'h0},
        '{16'h1400, 16'h6800, 8'h93, 4'd13, 1'b0, 1'b0, 32'h0, 32'h0},
        '{16'h0400, 16'h8400, 8'hE1, 4'd14, 1'b1, 1'b0, 32'h0, 32'h0}
    };

    initial
    begin
        logic [15:0] sh;
        logic [15:0] mh;
        q41_pkg::result_t r;
        int sent;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_run = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        scale_half = '0;
        min_half = '0;
        quant_byte = '0;
        byte_index = '0;
        end_of_row = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
            begin
                r = dequant_byte(directed_rows[i].scale, directed_rows[i].minimum,
                                 directed_rows[i].qbyte, directed_rows[i].index, 1'b0);
                if (r.low_value !== directed_rows[i].low_known)
                    report("table low_value", r.low_value, directed_rows[i].low_known);
                if (r.high_value !== directed_rows[i].high_known)
                    report("table high_value", r.high_value, directed_rows[i].high_known);
            end
            send_byte(directed_rows[i].scale, directed_rows[i].minimum,
                      directed_rows[i].qbyte, directed_rows[i].index, directed_rows[i].eor);
        end

        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            // Hold off once, mid-run, until the pipeline has fully drained.
            if (sent >= ITEM_COUNT / 2 && sent < ITEM_COUNT / 2 + 16)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                // Waiting on the clock lets the last accepted transaction reach the queue.
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
                sent = ITEM_COUNT / 2 + 16;
            end
            sh = pick_half();
            mh = pick_half();
            if ($urandom_range(0, 3) != 0)
            begin
                // A whole block with a shared scale and minimum.
                for (int b = 0; b < 16; b++)
                    send_byte(sh, mh, 8'($urandom), 4'(b), b == 15 && $urandom_range(0, 1));
                sent += 16;
            end
            else
            begin
                send_byte(sh, mh, 8'($urandom), 4'($urandom), 1'($urandom));
                sent++;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0d result transactions never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("PASS q4_1_block_dequantizer_unit");
        else
            $display("FAIL q4_1_block_dequantizer_unit");
        $finish;
    end

endmodule
